[rtl/core/tccs_pkg.sv]
// Shared types and constants of the text console engine.
// No dependencies; imported by every module of the block.
package tccs_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_BLANK     = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_COPY,
        PTR_BLANK,
        PTR_INC
    } ptr_op_t;

    typedef struct packed {
        logic    load_req;
        logic    put_en;
        logic    rd_idx;
        logic    copy_rd;
        logic    fill_en;
        logic    fill_init;
        logic    home;
        ptr_op_t ptr_op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       idx_ok;
        logic       need_scroll;
        logic       ptr_last;
    } dp_sts_t;

    typedef struct packed {
        logic        scrolled;
        logic [15:0] cell_val;
        logic [10:0] linear;
        logic [6:0]  col;
        logic [4:0]  row;
    } dp_res_t;

endpackage

[rtl/core/tccs_ctrl.sv]
// Sequencer of the text console engine: decodes each request and steps
// the datapath through fills, scroll copies and reads. Uses tccs_pkg.
module tccs_ctrl import tccs_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    out_free,
    input  dp_sts_t sts,
    output dp_cmd_t cmd,
    output logic    in_ready,
    output logic    out_load
);

    typedef enum logic [9:0] {
        ST_INIT   = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_DECODE = 10'b0000000100,
        ST_PUT    = 10'b0000001000,
        ST_SCROLL = 10'b0000010000,
        ST_DRAIN  = 10'b0000100000,
        ST_BLANK  = 10'b0001000000,
        ST_CLEAR  = 10'b0010000000,
        ST_READ   = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.ptr_op = PTR_HOLD;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_INIT: begin
                cmd.fill_en   = 1'b1;
                cmd.fill_init = 1'b1;
                cmd.ptr_op    = PTR_INC;
                if (sts.ptr_last) begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.req)
                    REQ_PUT: begin
                        state_next = ST_PUT;
                    end
                    REQ_CLEAR: begin
                        cmd.ptr_op = PTR_ZERO;
                        state_next = ST_CLEAR;
                    end
                    REQ_READ: begin
                        state_next = sts.idx_ok ? ST_READ : ST_DONE;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_PUT: begin
                cmd.put_en = 1'b1;
                if (sts.need_scroll) begin
                    cmd.ptr_op = PTR_COPY;
                    state_next = ST_SCROLL;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL: begin
                cmd.copy_rd = 1'b1;
                cmd.ptr_op  = PTR_INC;
                if (sts.ptr_last) begin
                    cmd.ptr_op = PTR_BLANK;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_BLANK;
            end
            ST_BLANK: begin
                cmd.fill_en = 1'b1;
                cmd.ptr_op  = PTR_INC;
                if (sts.ptr_last) begin
                    cmd.ptr_op = PTR_ZERO;
                    state_next = ST_DONE;
                end
            end
            ST_CLEAR: begin
                cmd.fill_en = 1'b1;
                cmd.ptr_op  = PTR_INC;
                if (sts.ptr_last) begin
                    cmd.ptr_op = PTR_ZERO;
                    cmd.home   = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_READ: begin
                cmd.rd_idx = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

[rtl/core/tccs_dp.sv]
// Datapath of the text console engine: screen store, cursor, attribute
// register and sweep pointer, driven by tccs_ctrl commands. Uses tccs_pkg.
module tccs_dp import tccs_pkg::*; #(
    parameter int SCREEN_COLS = DEF_COLS,
    parameter int SCREEN_ROWS = DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_sts_t     sts,
    input  logic [1:0]  req_type,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_index,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    output dp_res_t     res
);

    localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLS);

    localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
    localparam logic [AW-1:0] COLS_A      = AW'(SCREEN_COLS);
    localparam logic [AW-1:0] BLANK_START = AW'(CELLS - SCREEN_COLS);
    localparam logic [CW:0]   COLS_C      = (CW + 1)'(SCREEN_COLS);
    localparam logic [RW:0]   ROWS_C      = (RW + 1)'(SCREEN_ROWS);
    localparam logic [RW-1:0] LAST_ROW    = RW'(SCREEN_ROWS - 1);

    logic [15:0] screen_mem [CELLS];

    logic [1:0]    req_reg;
    logic [7:0]    char_reg;
    logic [10:0]   idx_reg;
    logic          idx_ok_reg;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          scroll_reg;
    logic [7:0]    attr_reg;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic          pend_reg;
    logic [AW-1:0] wptr_reg;
    logic [15:0]   rdata_reg;

    logic [AW-1:0] pos;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;
    logic          put_we;
    logic [AW-1:0] put_addr;
    logic [15:0]   put_data;
    logic [CW-1:0] put_col;
    logic          row_adv;
    logic          wrap;
    logic [RW-1:0] put_row;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;

    logic [31:0]   row_w, col_w, lin_w;

    assign pos     = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign col_inc = {1'b0, col_reg} + 1'b1;
    assign row_inc = {1'b0, row_reg} + 1'b1;

    always_comb begin
        put_we   = 1'b0;
        put_addr = pos;
        put_data = {attr_reg, char_reg};
        put_col  = col_reg;
        row_adv  = 1'b0;
        if (char_reg == CH_NEWLINE) begin
            put_col = '0;
            row_adv = 1'b1;
        end else if (char_reg == CH_BACKSPACE) begin
            if (col_reg != '0) begin
                put_col  = col_reg - 1'b1;
                put_we   = 1'b1;
                put_addr = pos - 1'b1;
                put_data = {attr_reg, CH_BLANK};
            end
        end else begin
            put_we = 1'b1;
            if (col_inc >= COLS_C) begin
                put_col = '0;
                row_adv = 1'b1;
            end else begin
                put_col = col_inc[CW-1:0];
            end
        end
    end

    assign wrap    = row_adv && (row_inc >= ROWS_C);
    assign put_row = wrap ? LAST_ROW : (row_adv ? row_inc[RW-1:0] : row_reg);

    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.home) begin
            row_next = '0;
            col_next = '0;
        end else if (cmd.put_en) begin
            row_next = put_row;
            col_next = put_col;
        end
    end

    always_comb begin
        ptr_next = ptr_reg;
        case (cmd.ptr_op)
            PTR_HOLD:  ptr_next = ptr_reg;
            PTR_ZERO:  ptr_next = '0;
            PTR_COPY:  ptr_next = COLS_A;
            PTR_BLANK: ptr_next = BLANK_START;
            PTR_INC:   ptr_next = ptr_reg + 1'b1;
            default:   ptr_next = ptr_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg    <= REQ_PUT;
            idx_ok_reg <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
            scroll_reg <= 1'b0;
            attr_reg   <= ATTR_RESET;
            ptr_reg    <= '0;
            pend_reg   <= 1'b0;
        end else begin
            if (cmd.load_req) begin
                req_reg    <= req_type;
                idx_ok_reg <= (32'(cell_index) < 32'(CELLS));
                scroll_reg <= 1'b0;
            end else if (cmd.put_en) begin
                scroll_reg <= wrap;
            end
            if (cfg_we) begin
                attr_reg <= cfg_data;
            end
            row_reg  <= row_next;
            col_reg  <= col_next;
            ptr_reg  <= ptr_next;
            pend_reg <= cmd.copy_rd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            char_reg <= char_code;
            idx_reg  <= cell_index;
        end
        wptr_reg <= ptr_reg - COLS_A;
    end

    // Store write port: pending scroll copy, then fills, then put.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = {attr_reg, CH_BLANK};
        if (pend_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wptr_reg;
            mem_wdata = rdata_reg;
        end else if (cmd.fill_en) begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg;
            mem_wdata = cmd.fill_init ? {ATTR_RESET, CH_BLANK} : {attr_reg, CH_BLANK};
        end else if (cmd.put_en && put_we) begin
            mem_we    = 1'b1;
            mem_waddr = put_addr;
            mem_wdata = put_data;
        end
    end

    assign mem_re    = cmd.copy_rd | cmd.rd_idx;
    assign mem_raddr = cmd.copy_rd ? ptr_reg : AW'(idx_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= screen_mem[mem_raddr];
        end
    end

    assign sts.req         = req_reg;
    assign sts.idx_ok      = idx_ok_reg;
    assign sts.need_scroll = wrap;
    assign sts.ptr_last    = (ptr_reg == LAST_ADDR);

    assign row_w = 32'(row_reg);
    assign col_w = 32'(col_reg);
    assign lin_w = 32'(pos);

    assign res.row      = row_w[4:0];
    assign res.col      = col_w[6:0];
    assign res.linear   = lin_w[10:0];
    assign res.cell_val = (req_reg == REQ_READ && idx_ok_reg) ? rdata_reg : 16'h0000;
    assign res.scrolled = scroll_reg;

endmodule

[rtl/core/text_console_cursor_scroll.sv]
// Text console engine, top level: stream ports, result register and the
// tccs_ctrl / tccs_dp pair. Uses tccs_pkg.
//
// After reset the screen store is filled with blank cells, one cell per
// cycle, before the first request is taken; attribute writes are taken at
// any time. A put that scrolls and a clear go through the single write
// port of the screen store, which moves or blanks one cell per cycle. The
// result register lets the next request in while the previous result
// waits on m_tready.
module text_console_cursor_scroll import tccs_pkg::*; #(
    parameter int SCREEN_COLS = DEF_COLS,
    parameter int SCREEN_ROWS = DEF_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero[23:19]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // cursor_row_out[4:0], cursor_col_out[11:5],
                                   // cursor_linear[22:12], cell_value[38:23], scrolled[39]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data   // text_attribute[7:0]
);

    dp_cmd_t cmd;
    dp_sts_t sts;
    dp_res_t res;
    logic    out_free;
    logic    out_load;

    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    tccs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd),
        .in_ready (s_tready),
        .out_load (out_load)
    );

    tccs_dp #(
        .SCREEN_COLS (SCREEN_COLS),
        .SCREEN_ROWS (SCREEN_ROWS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .req_type   (s_tuser),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {res.scrolled, res.cell_val, res.linear, res.col, res.row};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[rtl/core/tccs_checker.sv]
// Port-level checks of text_console_cursor_scroll, bound to the top level.
// Sees the top-level ports only; defaults from tccs_pkg.
module tccs_checker import tccs_pkg::*; #(
    parameter int SCREEN_COLS = DEF_COLS,
    parameter int SCREEN_ROWS = DEF_ROWS
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    localparam bit EXACT = (SCREEN_ROWS <= 32) && (SCREEN_COLS <= 128);
    localparam logic [4:0] LAST_ROW = 5'(SCREEN_ROWS - 1);

    logic [31:0] lin_calc;
    assign lin_calc = 32'(m_tdata[4:0]) * 32'(SCREEN_COLS) + 32'(m_tdata[11:5]);

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented straight after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_linear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && EXACT |-> m_tdata[22:12] == lin_calc[10:0])
        else $error("cursor linear position disagrees with row and column");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && EXACT |->
            32'(m_tdata[4:0]) < 32'(SCREEN_ROWS) && 32'(m_tdata[11:5]) < 32'(SCREEN_COLS))
        else $error("cursor outside the screen");

    a_scroll_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[39] |-> m_tdata[4:0] == LAST_ROW && m_tdata[38:23] == 16'h0000)
        else $error("scroll result not pinned to the last row");

endmodule

bind text_console_cursor_scroll tccs_checker #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tccs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
